// File: src/hrhp_pkg.sv
// ============================================================================
// hrhp_pkg
// Shared types, constants and pattern functions for the HTTP response
// header parser.
// ============================================================================
`default_nettype none

package hrhp_pkg;

    localparam int MAX_LENGTH_DIGITS = 9;
    localparam int DIGIT_W           = $clog2(MAX_LENGTH_DIGITS + 1);
    localparam int VALUE_W           = 30;
    localparam int NF_W              = 4;
    localparam int NAME_W            = 5;
    localparam int QUEUE_DEPTH       = 2;
    localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

    localparam logic [NF_W-1:0]    NF_LEN     = 4'd13;
    localparam logic [NAME_W-1:0]  NAME_LEN   = 5'd15;
    localparam logic [NAME_W-1:0]  NAME_FAIL  = 5'd16;
    localparam logic [NAME_W-1:0]  VALUE_END  = 5'd17;
    localparam logic [VALUE_W-1:0] VALUE_MAX  = 30'd999999999;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_DONE   = 2'd2,
        PH_ERROR  = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] lc;
        logic       is_lf;
        logic       is_cr;
        logic       is_digit;
        logic       is_blank;
        logic [3:0] digit;
    } t_item;

    function automatic logic [7:0] nf_char(input logic [NF_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "4";
            4'd1:    ch = "0";
            4'd2:    ch = "4";
            4'd3:    ch = " ";
            4'd4:    ch = "n";
            4'd5:    ch = "o";
            4'd6:    ch = "t";
            4'd7:    ch = " ";
            4'd8:    ch = "f";
            4'd9:    ch = "o";
            4'd10:   ch = "u";
            4'd11:   ch = "n";
            4'd12:   ch = "d";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            4'd14:   ch = ":";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Failure link of the "404 not found" matcher: only the blank after
    // "404" can fall back to a partial match of length one.
    function automatic logic [NF_W-1:0] nf_next(input logic [NF_W-1:0] p,
                                                 input logic [7:0] c);
        logic [NF_W-1:0] q;
        q = p;
        for (int i = 0; i < 2; i++) begin
            if (q != '0 && nf_char(q) != c) begin
                q = (q == 4'd3) ? 4'd1 : 4'd0;
            end
        end
        if (nf_char(q) == c) begin
            q = q + 4'd1;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// File: src/hrhp_front.sv
// ============================================================================
// hrhp_front
// Input side: accepts bytes and classifies them for the parser core.
// ============================================================================
`default_nettype none

module hrhp_front (
    input  wire logic          [7:0] i_data_byte,
    input  wire logic                i_valid,
    output      logic                o_ready,
    input  wire logic                i_full,
    output      logic                o_push,
    output      hrhp_pkg::t_item     o_item
);
    import hrhp_pkg::*;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_item          = '0;
        o_item.lc       = i_data_byte;
        if (i_data_byte inside {[8'h41:8'h5A]}) begin
            o_item.lc = i_data_byte + 8'd32;
        end
        o_item.is_lf    = (i_data_byte == CH_LF);
        o_item.is_cr    = (i_data_byte == CH_CR);
        o_item.is_digit = (i_data_byte inside {[8'h30:8'h39]});
        o_item.is_blank = (i_data_byte == CH_SPACE) || (i_data_byte == CH_TAB);
        o_item.digit    = i_data_byte[3:0];
    end

endmodule

`default_nettype wire

// File: src/hrhp_queue.sv
// ============================================================================
// hrhp_queue
// Short queue of classified bytes between the front and the parser core.
// ============================================================================
`default_nettype none

module hrhp_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire hrhp_pkg::t_item     i_item,
    output      logic                o_full,
    input  wire logic                i_pop,
    output      logic                o_valid,
    output      hrhp_pkg::t_item     o_item
);
    import hrhp_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: src/hrhp_back.sv
// ============================================================================
// hrhp_back
// Parser core: header matchers, length parsing, body counting and the
// output register.
// ============================================================================
`default_nettype none

module hrhp_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_info_only_mode,
    input  wire logic                              i_q_valid,
    input  wire hrhp_pkg::t_item                   i_q_item,
    output      logic                              o_q_pop,
    output      logic                              o_valid,
    input  wire logic                              i_ready,
    output      logic [1:0]                        o_status,
    output      logic                              o_body_valid,
    output      logic [hrhp_pkg::VALUE_W-1:0]      o_body_offset,
    output      logic [hrhp_pkg::VALUE_W-1:0]      o_content_length
);
    import hrhp_pkg::*;

    t_phase             r_phase, n_phase;
    logic               r_line_has, n_line_has;
    logic [NF_W-1:0]    r_nf_pos, n_nf_pos;
    logic [NAME_W-1:0]  r_name_pos, n_name_pos;
    logic [VALUE_W-1:0] r_line_value, n_line_value;
    logic [DIGIT_W-1:0] r_digit_cnt, n_digit_cnt;
    logic               r_length_seen, n_length_seen;
    logic [VALUE_W-1:0] r_decl_len, n_decl_len;
    logic [VALUE_W-1:0] r_body_cnt, n_body_cnt;

    logic               r_o_valid;
    logic [1:0]         r_o_status;
    logic               r_o_body_valid;
    logic [VALUE_W-1:0] r_o_body_offset;
    logic [VALUE_W-1:0] r_o_content_length;

    logic               res_body_valid;
    logic [VALUE_W-1:0] res_body_offset;
    logic [VALUE_W+3:0] value_times_ten;
    logic               advance;

    assign advance = i_q_valid && (!r_o_valid || i_ready);
    assign o_q_pop = advance;

    assign value_times_ten = {r_line_value, 3'b000} + {2'b00, r_line_value, 1'b0}
                           + {{(VALUE_W){1'b0}}, i_q_item.digit};

    // Next-state logic of the parser.
    always_comb begin
        n_phase       = r_phase;
        n_line_has    = r_line_has;
        n_nf_pos      = r_nf_pos;
        n_name_pos    = r_name_pos;
        n_line_value  = r_line_value;
        n_digit_cnt   = r_digit_cnt;
        n_length_seen = r_length_seen;
        n_decl_len    = r_decl_len;
        n_body_cnt    = r_body_cnt;
        case (r_phase)
            PH_HEADER: begin
                if (i_q_item.is_lf) begin
                    if (r_line_has) begin
                        if (r_nf_pos >= NF_LEN) begin
                            n_phase = PH_ERROR;
                        end else if (r_name_pos == NAME_LEN || r_name_pos == VALUE_END) begin
                            n_decl_len    = r_line_value;
                            n_length_seen = 1'b1;
                            if (!i_info_only_mode && r_line_value == '0) begin
                                n_phase = PH_ERROR;
                            end
                        end
                        n_line_has   = 1'b0;
                        n_nf_pos     = '0;
                        n_name_pos   = '0;
                        n_line_value = '0;
                        n_digit_cnt  = '0;
                    end else if (i_info_only_mode) begin
                        n_phase = PH_DONE;
                    end else if (!r_length_seen || r_decl_len == '0) begin
                        n_phase = PH_ERROR;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end else if (!i_q_item.is_cr) begin
                    n_line_has = 1'b1;
                    if (r_nf_pos < NF_LEN) begin
                        n_nf_pos = nf_next(r_nf_pos, i_q_item.lc);
                    end
                    if (r_name_pos < NAME_LEN) begin
                        n_name_pos = (name_char(r_name_pos[3:0]) == i_q_item.lc)
                                   ? r_name_pos + 1'b1 : NAME_FAIL;
                    end else if (r_name_pos == NAME_LEN) begin
                        if (i_q_item.is_digit) begin
                            if (r_digit_cnt < DIGIT_W'(MAX_LENGTH_DIGITS)) begin
                                n_line_value = (value_times_ten > {4'b0000, VALUE_MAX})
                                             ? VALUE_MAX : value_times_ten[VALUE_W-1:0];
                                n_digit_cnt  = r_digit_cnt + 1'b1;
                            end else begin
                                n_name_pos = VALUE_END;
                            end
                        end else if (!(r_digit_cnt == '0 && i_q_item.is_blank)) begin
                            n_name_pos = VALUE_END;
                        end
                    end
                end
            end
            PH_BODY: begin
                if (r_body_cnt >= r_decl_len) begin
                    n_phase = PH_ERROR;
                end else begin
                    n_body_cnt = r_body_cnt + 1'b1;
                    if (n_body_cnt == r_decl_len) begin
                        n_phase = PH_DONE;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Result fields of the byte being processed.
    always_comb begin
        res_body_valid  = 1'b0;
        res_body_offset = '0;
        if (r_phase == PH_BODY && r_body_cnt < r_decl_len) begin
            res_body_valid  = 1'b1;
            res_body_offset = r_body_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_line_has    <= 1'b0;
            r_nf_pos      <= '0;
            r_name_pos    <= '0;
            r_line_value  <= '0;
            r_digit_cnt   <= '0;
            r_length_seen <= 1'b0;
            r_decl_len    <= '0;
            r_body_cnt    <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            if (advance) begin
                r_phase       <= n_phase;
                r_line_has    <= n_line_has;
                r_nf_pos      <= n_nf_pos;
                r_name_pos    <= n_name_pos;
                r_line_value  <= n_line_value;
                r_digit_cnt   <= n_digit_cnt;
                r_length_seen <= n_length_seen;
                r_decl_len    <= n_decl_len;
                r_body_cnt    <= n_body_cnt;
                r_o_valid     <= 1'b1;
            end else if (i_ready) begin
                r_o_valid     <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_status         <= n_phase;
            r_o_body_valid     <= res_body_valid;
            r_o_body_offset    <= res_body_offset;
            r_o_content_length <= n_decl_len;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_body_valid     = r_o_body_valid;
    assign o_body_offset    = r_o_body_offset;
    assign o_content_length = r_o_content_length;

endmodule

`default_nettype wire

// File: src/http_response_header_parser_top.sv
// A byte accepted on the input is written into the queue, then processed by
// the parser core into the registered result transaction.
// Throughput: one byte per cycle while the output side is not stalled.
// A two-entry queue separates the input side from the parser core.
// Reset is synchronous and active low; it clears the parser state, the queue
// and the info-only register, and needs no clearing pass.
// ============================================================================
// http_response_header_parser_top
// HTTP response header parser with content-length body counting.
// ============================================================================
`default_nettype none

module http_response_header_parser_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    output      logic                         o_cfg_ready,
    input  wire logic                         i_cfg_info_only_mode,
    input  wire logic                         i_valid,
    output      logic                         o_ready,
    input  wire logic [7:0]                   i_data_byte,
    output      logic                         o_valid,
    input  wire logic                         i_ready,
    output      logic [1:0]                   o_status,
    output      logic                         o_body_valid,
    output      logic [hrhp_pkg::VALUE_W-1:0] o_body_offset,
    output      logic [hrhp_pkg::VALUE_W-1:0] o_content_length
);
    import hrhp_pkg::*;

    logic  r_info_only_mode;
    logic  q_full;
    logic  q_push;
    logic  q_pop;
    logic  q_valid;
    t_item f_item;
    t_item q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_info_only_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_info_only_mode <= i_cfg_info_only_mode;
        end
    end

    hrhp_front u_front (
        .i_data_byte (i_data_byte),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_item      (f_item)
    );

    hrhp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    hrhp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_info_only_mode (r_info_only_mode),
        .i_q_valid        (q_valid),
        .i_q_item         (q_item),
        .o_q_pop          (q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_body_valid     (o_body_valid),
        .o_body_offset    (o_body_offset),
        .o_content_length (o_content_length)
    );

endmodule

`default_nettype wire

// File: src/hrhp_checker.sv
// ============================================================================
// hrhp_checker
// Port-level checks of the header parser, bound to the top level.
// ============================================================================
`default_nettype none

module hrhp_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         o_valid,
    input  wire logic                         i_ready,
    input  wire logic [1:0]                   o_status,
    input  wire logic                         o_body_valid,
    input  wire logic [hrhp_pkg::VALUE_W-1:0] o_body_offset,
    input  wire logic [hrhp_pkg::VALUE_W-1:0] o_content_length
);
    import hrhp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("Output transaction dropped before it was taken.");

    a_body_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_body_valid |-> (o_status == PH_BODY || o_status == PH_DONE))
        else $error("Body byte reported outside the body or done phase.");

    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_body_valid |-> o_body_offset == '0)
        else $error("Nonzero offset on a transaction without a body byte.");

    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_body_valid |-> o_body_offset < o_content_length)
        else $error("Body offset is not below the declared length.");

endmodule

bind http_response_header_parser_top hrhp_checker u_hrhp_checker (.*);

`default_nettype wire
